// File: hw/rtl/brs_pkg.sv
// shared types and constants of the bilinear image resampler
// no dependencies; used by every module in hw/rtl
package brs_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned StepW     = 28;
  localparam int unsigned DimW      = 13;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned IdxW      = 16;
  localparam int unsigned PixW      = 32;
  localparam int unsigned ChW       = 8;
  localparam int unsigned NumNbr    = 4;
  localparam int unsigned SxW       = CoordW + StepW;
  localparam int unsigned IntW      = SxW - FracBits;
  localparam int unsigned RowW      = 2 * DimW;
  localparam int unsigned AddrSumW  = RowW + 1;
  localparam int unsigned OneW      = FracBits + 1;
  localparam int unsigned WeightW   = 2 * OneW;
  localparam int unsigned ProdW     = WeightW + ChW;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned CntW      = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 28;

  localparam int unsigned MaxPixelsDef   = 65536;
  localparam int unsigned MaxChannelsDef = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgSrcWidth    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcHeight   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgChannelCnt  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgXStep       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgYStep       = 3'd4;

  localparam logic [DimW-1:0]  RstSrcWidth  = 13'd256;
  localparam logic [DimW-1:0]  RstSrcHeight = 13'd256;
  localparam logic [CntW-1:0]  RstChannels  = 3'd4;
  localparam logic [StepW-1:0] RstStep      = 28'd65536;

  localparam logic [0:0] CmdWrite   = 1'b0;
  localparam logic [0:0] CmdCompute = 1'b1;

  typedef struct packed {
    logic [0:0]        cmd;
    logic [IdxW-1:0]   src_index;
    logic [ChW-1:0]    in_c0;
    logic [ChW-1:0]    in_c1;
    logic [ChW-1:0]    in_c2;
    logic [ChW-1:0]    in_c3;
    logic [CoordW-1:0] dst_x;
    logic [CoordW-1:0] dst_y;
  } req_t;

  typedef struct packed {
    logic [ChW-1:0] out_c0;
    logic [ChW-1:0] out_c1;
    logic [ChW-1:0] out_c2;
    logic [ChW-1:0] out_c3;
  } res_t;

  typedef struct packed {
    logic [DimW-1:0]  src_width;
    logic [DimW-1:0]  src_height;
    logic [CntW-1:0]  channel_count;
    logic [StepW-1:0] x_step;
    logic [StepW-1:0] y_step;
  } cfg_t;

  // word handed from the coordinate pipe to the store and blender
  // neighbor order: top-left, top-right, bottom-left, bottom-right
  typedef struct packed {
    logic                              valid;
    logic                              compute;
    logic                              wr_en;
    logic [NumNbr-1:0][AddrSumW-1:0]   addr;
    logic [NumNbr-1:0]                 oob;
    logic [PixW-1:0]                   pix;
    logic [NumNbr-1:0][WeightW-1:0]    weight;
  } issue_t;

endpackage

// File: hw/rtl/brs_coord.sv
// coordinate pipe: step scaling, edge clamp, address and weight generation
// depends on brs_pkg
module brs_coord #(
  parameter int unsigned MAX_PIXELS = brs_pkg::MaxPixelsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  brs_pkg::req_t   req_i,
  input  brs_pkg::cfg_t   cfg_i,
  output brs_pkg::issue_t issue_o
);

  localparam logic [brs_pkg::AddrSumW-1:0] MaxPix = brs_pkg::AddrSumW'(MAX_PIXELS);
  localparam logic [brs_pkg::OneW-1:0] One = brs_pkg::OneW'(1) << brs_pkg::FracBits;

  typedef struct packed {
    logic [0:0]                  cmd;
    logic [brs_pkg::IdxW-1:0]    idx;
    logic [brs_pkg::PixW-1:0]    pix;
  } side_t;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  side_t s1_q, s2_q, s3_q, s4_q;
  logic [brs_pkg::CoordW-1:0] dx1_q, dy1_q;
  logic [brs_pkg::SxW-1:0] sx2_q, sy2_q;
  logic [brs_pkg::DimW-1:0] x0_3_q, x1_3_q, y0_3_q, y1_3_q;
  logic [brs_pkg::FracBits-1:0] fx3_q, fy3_q;
  logic [brs_pkg::DimW-1:0] x0_4_q, x1_4_q;
  logic [brs_pkg::RowW-1:0] ry0_4_q, ry1_4_q;
  logic [brs_pkg::NumNbr-1:0][brs_pkg::WeightW-1:0] wt4_q;
  brs_pkg::issue_t issue_d, issue_q;

  logic [brs_pkg::DimW-1:0] weff, heff, wm1, hm1;
  logic [brs_pkg::IntW-1:0] ix, iy;
  logic [brs_pkg::IntW:0] ix1, iy1;
  logic [brs_pkg::OneW-1:0] ox, oy, px, py;

  assign weff = (cfg_i.src_width  == '0) ? brs_pkg::DimW'(1) : cfg_i.src_width;
  assign heff = (cfg_i.src_height == '0) ? brs_pkg::DimW'(1) : cfg_i.src_height;
  assign wm1  = weff - brs_pkg::DimW'(1);
  assign hm1  = heff - brs_pkg::DimW'(1);

  assign ix  = sx2_q[brs_pkg::SxW-1:brs_pkg::FracBits];
  assign iy  = sy2_q[brs_pkg::SxW-1:brs_pkg::FracBits];
  assign ix1 = {1'b0, ix} + (brs_pkg::IntW+1)'(1);
  assign iy1 = {1'b0, iy} + (brs_pkg::IntW+1)'(1);

  assign px = {1'b0, fx3_q};
  assign py = {1'b0, fy3_q};
  assign ox = One - px;
  assign oy = One - py;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 1: capture
  always_ff @(posedge clk_i) begin
    s1_q  <= '{cmd: req_i.cmd, idx: req_i.src_index,
               pix: {req_i.in_c3, req_i.in_c2, req_i.in_c1, req_i.in_c0}};
    dx1_q <= req_i.dst_x;
    dy1_q <= req_i.dst_y;
  end

  // stage 2: scale by step
  always_ff @(posedge clk_i) begin
    s2_q  <= s1_q;
    sx2_q <= brs_pkg::SxW'(dx1_q) * brs_pkg::SxW'(cfg_i.x_step);
    sy2_q <= brs_pkg::SxW'(dy1_q) * brs_pkg::SxW'(cfg_i.y_step);
  end

  // stage 3: split and clamp to the last column and row
  always_ff @(posedge clk_i) begin
    s3_q   <= s2_q;
    x0_3_q <= (ix  < brs_pkg::IntW'(wm1))     ? ix[brs_pkg::DimW-1:0]  : wm1;
    x1_3_q <= (ix1 < (brs_pkg::IntW+1)'(wm1)) ? ix1[brs_pkg::DimW-1:0] : wm1;
    y0_3_q <= (iy  < brs_pkg::IntW'(hm1))     ? iy[brs_pkg::DimW-1:0]  : hm1;
    y1_3_q <= (iy1 < (brs_pkg::IntW+1)'(hm1)) ? iy1[brs_pkg::DimW-1:0] : hm1;
    fx3_q  <= sx2_q[brs_pkg::FracBits-1:0];
    fy3_q  <= sy2_q[brs_pkg::FracBits-1:0];
  end

  // stage 4: row offsets and corner weights
  always_ff @(posedge clk_i) begin
    s4_q     <= s3_q;
    x0_4_q   <= x0_3_q;
    x1_4_q   <= x1_3_q;
    ry0_4_q  <= brs_pkg::RowW'(y0_3_q) * brs_pkg::RowW'(weff);
    ry1_4_q  <= brs_pkg::RowW'(y1_3_q) * brs_pkg::RowW'(weff);
    wt4_q[0] <= brs_pkg::WeightW'(ox) * brs_pkg::WeightW'(oy);
    wt4_q[1] <= brs_pkg::WeightW'(px) * brs_pkg::WeightW'(oy);
    wt4_q[2] <= brs_pkg::WeightW'(ox) * brs_pkg::WeightW'(py);
    wt4_q[3] <= brs_pkg::WeightW'(px) * brs_pkg::WeightW'(py);
  end

  // stage 5: linear addresses, range checks; writes use the top-left slot
  always_comb begin
    issue_d         = '0;
    issue_d.valid   = v4_q;
    issue_d.compute = v4_q && (s4_q.cmd == brs_pkg::CmdCompute);
    issue_d.pix     = s4_q.pix;
    issue_d.weight  = wt4_q;
    if (s4_q.cmd == brs_pkg::CmdWrite) begin
      issue_d.addr[0] = brs_pkg::AddrSumW'(s4_q.idx);
      issue_d.wr_en   = v4_q && (brs_pkg::AddrSumW'(s4_q.idx) < MaxPix);
    end else begin
      issue_d.addr[0] = brs_pkg::AddrSumW'(ry0_4_q) + brs_pkg::AddrSumW'(x0_4_q);
      issue_d.addr[1] = brs_pkg::AddrSumW'(ry0_4_q) + brs_pkg::AddrSumW'(x1_4_q);
      issue_d.addr[2] = brs_pkg::AddrSumW'(ry1_4_q) + brs_pkg::AddrSumW'(x0_4_q);
      issue_d.addr[3] = brs_pkg::AddrSumW'(ry1_4_q) + brs_pkg::AddrSumW'(x1_4_q);
    end
    for (int n = 0; n < brs_pkg::NumNbr; n++) begin
      issue_d.oob[n] = (issue_d.addr[n] >= MaxPix);
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q <= issue_d;
  end

  always_comb begin
    issue_o       = issue_q;
    issue_o.valid = v5_q;
    issue_o.compute = v5_q && issue_q.compute;
    issue_o.wr_en = v5_q && issue_q.wr_en;
  end

endmodule

// File: hw/rtl/brs_store.sv
// frame store: two copies, each with one write and two read ports
// depends on brs_pkg
module brs_store #(
  parameter int unsigned MAX_PIXELS = brs_pkg::MaxPixelsDef
) (
  input  logic                                          clk_i,
  input  brs_pkg::issue_t                               issue_i,
  output logic [brs_pkg::NumNbr-1:0][brs_pkg::PixW-1:0] rdata_o
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  // top row copy serves the top neighbors, bottom copy the bottom ones
  logic [brs_pkg::PixW-1:0] mem_top [MAX_PIXELS];
  logic [brs_pkg::PixW-1:0] mem_bot [MAX_PIXELS];
  logic [brs_pkg::NumNbr-1:0][brs_pkg::PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (issue_i.wr_en) begin
      mem_top[issue_i.addr[0][AW-1:0]] <= issue_i.pix;
      mem_bot[issue_i.addr[0][AW-1:0]] <= issue_i.pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.compute) begin
      rdata_q[0] <= mem_top[issue_i.addr[0][AW-1:0]];
      rdata_q[1] <= mem_top[issue_i.addr[1][AW-1:0]];
      rdata_q[2] <= mem_bot[issue_i.addr[2][AW-1:0]];
      rdata_q[3] <= mem_bot[issue_i.addr[3][AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/brs_blend.sv
// blender: weight products per channel, sum, truncate and clamp; out-of-range neighbors and inactive channels give zero
// depends on brs_pkg
module brs_blend (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  brs_pkg::issue_t                               issue_i,
  input  logic [brs_pkg::NumNbr-1:0][brs_pkg::PixW-1:0] rdata_i,
  input  logic [brs_pkg::CntW-1:0]                      nch_i,
  output logic                                          res_valid_o,
  output brs_pkg::res_t                                 res_o
);

  localparam int unsigned NumCh = brs_pkg::PixW / brs_pkg::ChW;

  logic v6_q, v7_q, v8_q;
  logic [brs_pkg::NumNbr-1:0] oob6_q;
  logic [brs_pkg::NumNbr-1:0][brs_pkg::WeightW-1:0] wt6_q;
  logic [NumCh-1:0][brs_pkg::NumNbr-1:0][brs_pkg::ProdW-1:0] prod7_q;
  logic [NumCh-1:0][brs_pkg::ChW-1:0] out_d, out_q;
  logic [NumCh-1:0][brs_pkg::ChW-1:0] pel [brs_pkg::NumNbr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v6_q <= issue_i.compute;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  // line up weights with the registered read data
  always_ff @(posedge clk_i) begin
    oob6_q <= issue_i.oob;
    wt6_q  <= issue_i.weight;
  end

  always_comb begin
    for (int n = 0; n < brs_pkg::NumNbr; n++) begin
      pel[n] = oob6_q[n] ? '0 : rdata_i[n];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumCh; c++) begin
      for (int n = 0; n < brs_pkg::NumNbr; n++) begin
        prod7_q[c][n] <= brs_pkg::ProdW'(pel[n][c]) * brs_pkg::ProdW'(wt6_q[n]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      logic [brs_pkg::SumW-1:0] sum;
      logic [brs_pkg::SumW-2*brs_pkg::FracBits-1:0] val;
      sum = brs_pkg::SumW'(prod7_q[c][0]) + brs_pkg::SumW'(prod7_q[c][1])
          + brs_pkg::SumW'(prod7_q[c][2]) + brs_pkg::SumW'(prod7_q[c][3]);
      val = sum[brs_pkg::SumW-1:2*brs_pkg::FracBits];
      if (brs_pkg::CntW'(c) >= nch_i) begin
        out_d[c] = '0;
      end else if (val > (brs_pkg::SumW-2*brs_pkg::FracBits)'(255)) begin
        out_d[c] = '1;
      end else begin
        out_d[c] = val[brs_pkg::ChW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = v8_q;
  assign res_o = '{out_c0: out_q[0], out_c1: out_q[1], out_c2: out_q[2], out_c3: out_q[3]};

endmodule

// File: hw/rtl/bilinear_image_resampler.sv
// bilinear image resampler, top level
// depends on brs_pkg, brs_coord, brs_store, brs_blend
//
// usage
// - a word on req_i is taken at each rising edge with start high and busy
//   low; busy stays low, so a word can be taken in every cycle
// - cmd write stores one source pixel at src_index (indexes past the store
//   depth are dropped); cmd compute returns one interpolated pixel
// - configuration goes through cfg_valid_i / cfg_index_i / cfg_data_i;
//   cfg_ready_o is always high; write registers only while the pipe is empty
// - each compute word gives exactly one result, shown on res_o for one cycle
//   with res_valid_o high once the word has passed the pipe; writes give none
// - throughput is one word per clock: an 8-stage pipe with the frame store
//   held twice, so the four neighbors come from two dual-read copies
// - writes reach the store at the same pipe stage as compute reads, so words
//   keep their order against the store
// - the receiver cannot stall the result channel, so nothing ever holds back
// - reset empties the pipe and loads the register defaults; the frame store
//   is not cleared and holds garbage until written
module bilinear_image_resampler #(
  parameter int unsigned MAX_PIXELS   = brs_pkg::MaxPixelsDef,
  parameter int unsigned MAX_CHANNELS = brs_pkg::MaxChannelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  brs_pkg::req_t                 req_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [brs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [brs_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          res_valid_o,
  output brs_pkg::res_t                 res_o
);

  brs_pkg::cfg_t cfg_q, cfg_d;
  brs_pkg::issue_t issue;
  logic [brs_pkg::NumNbr-1:0][brs_pkg::PixW-1:0] rdata;
  logic [brs_pkg::CntW-1:0] nch;
  logic accept;

  // the pipe never stalls
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // register file; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        brs_pkg::CfgSrcWidth:   cfg_d.src_width     = cfg_data_i[brs_pkg::DimW-1:0];
        brs_pkg::CfgSrcHeight:  cfg_d.src_height    = cfg_data_i[brs_pkg::DimW-1:0];
        brs_pkg::CfgChannelCnt: cfg_d.channel_count = cfg_data_i[brs_pkg::CntW-1:0];
        brs_pkg::CfgXStep:      cfg_d.x_step        = cfg_data_i[brs_pkg::StepW-1:0];
        brs_pkg::CfgYStep:      cfg_d.y_step        = cfg_data_i[brs_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{src_width: brs_pkg::RstSrcWidth, src_height: brs_pkg::RstSrcHeight,
                 channel_count: brs_pkg::RstChannels, x_step: brs_pkg::RstStep,
                 y_step: brs_pkg::RstStep};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // active channel count: zero means one, saturate at the channel limit
  always_comb begin
    if (cfg_q.channel_count == '0) begin
      nch = brs_pkg::CntW'(1);
    end else if (cfg_q.channel_count > brs_pkg::CntW'(MAX_CHANNELS)) begin
      nch = brs_pkg::CntW'(MAX_CHANNELS);
    end else begin
      nch = cfg_q.channel_count;
    end
  end

  // stages 1-5: scale, clamp, addresses and weights
  brs_coord #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_coord (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(accept),
    .req_i     (req_i),
    .cfg_i     (cfg_q),
    .issue_o   (issue)
  );

  // stage 6: store write or four neighbor reads
  brs_store #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_store (
    .clk_i  (clk_i),
    .issue_i(issue),
    .rdata_o(rdata)
  );

  // stages 7-8: products, sum, clamp
  brs_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .rdata_i    (rdata),
    .nch_i      (nch),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

`ifndef SYNTHESIS
  // every compute word comes out of the pipe as a result
  a_compute_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.cmd == brs_pkg::CmdCompute) |-> ##8 res_valid_o)
    else $error("compute word lost in pipe");

  // a write word never produces a result
  a_write_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.cmd == brs_pkg::CmdWrite) |-> ##8 !res_valid_o)
    else $error("write word produced a result");

  // the store sees either a write or a read in one cycle, never both
  a_store_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(issue.wr_en && issue.compute))
    else $error("store write and read issued together");
`endif

endmodule
